// ===== src/assert_macros.svh =====
// Assertion macros shared by the friction compensation RTL.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define JVFC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jvfc assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define JVFC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jvfc assertion failed");

`endif

// ===== src/jvfc_pkg.sv =====
// Types and constants for the joint velocity and friction compensation block.
// No dependencies; jvfc_ctrl, jvfc_dp, the top level and the testbench import this package.
package jvfc_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_VELOCITY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VISCOUS_POS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COULOMB_POS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VISCOUS_NEG    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COULOMB_NEG    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_STATIC_SLOPE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FRICTION_SCALE = 3'd6;
	localparam int CFG_DATA_W = 32;

	// Divide-by-three unit: the magnitude is split into 12-bit digits.
	localparam int MAG_W      = 36;
	localparam int DIGIT_W    = 12;
	localparam int DIV_DIGITS = MAG_W / DIGIT_W;
	localparam int DCNT_W     = $clog2(DIV_DIGITS);
	localparam int REM_W      = 2;
	localparam int DV_W       = DIGIT_W + REM_W;
	localparam int RECIP_SH   = 16;
	localparam int RECIP_W    = DV_W + RECIP_SH - 1;
	// ceil(2^16 / 3); exact floor(v / 3) for all v below 2^15.
	localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'(21846);
	// Smallest numerator that saturates for either sign: 3 * 2^31 + 3.
	localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(64'd6442450947);

	// Channel payloads.
	typedef struct packed {
		logic signed [31:0] joint_angle;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] filtered_velocity;
		logic signed [31:0] friction_torque;
	} result_t;

	// Commands from the controller to the datapath, one per step.
	typedef struct packed {
		logic load;
		logic raw;
		logic sum;
		logic mag;
		logic div;
		logic vel;
		logic sel;
		logic mul1;
		logic acc;
		logic mul2;
		logic rnd2;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic div_last;
	} status_t;

endpackage

// ===== src/jvfc_stream_if.sv =====
// Valid/ready stream channel carrying one payload of a chosen type.
// Payload types come from jvfc_pkg.
interface jvfc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== src/jvfc_ctrl.sv =====
// Controller state machine sequencing one sample through the datapath.
// Depends on jvfc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jvfc_ctrl import jvfc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output cmd_t    cmd,
	input  status_t st
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RAW  = 4'd1;
	localparam logic [3:0] S_SUM  = 4'd2;
	localparam logic [3:0] S_MAG  = 4'd3;
	localparam logic [3:0] S_DIV  = 4'd4;
	localparam logic [3:0] S_VEL  = 4'd5;
	localparam logic [3:0] S_SEL  = 4'd6;
	localparam logic [3:0] S_MUL1 = 4'd7;
	localparam logic [3:0] S_ACC  = 4'd8;
	localparam logic [3:0] S_MUL2 = 4'd9;
	localparam logic [3:0] S_RND2 = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	// The result register can take a new value when empty or being drained.
	assign out_free  = !out_valid_q || out_ready;

	// Next state and step commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RAW;
				end
			end
			S_RAW: begin
				cmd.raw = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_MAG;
			end
			S_MAG: begin
				cmd.mag = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				if (st.div_last) begin
					state_d = S_VEL;
				end
			end
			S_VEL: begin
				cmd.vel = 1'b1;
				state_d = S_SEL;
			end
			S_SEL: begin
				cmd.sel = 1'b1;
				state_d = S_MUL1;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_RND2;
			end
			S_RND2: begin
				if (out_free) begin
					cmd.rnd2 = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.rnd2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A stalled result is never overwritten.
	`JVFC_ASSERT_NEXT(a_stall_holds, state_q == S_RND2 && out_valid_q && !out_ready, state_q == S_RND2)
	// Every accepted sample starts the sequence.
	`JVFC_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_q == S_RAW)
	// The division leaves after its last digit.
	`JVFC_ASSERT_NEXT(a_div_exits, state_q == S_DIV && st.div_last, state_q == S_VEL)

endmodule

// ===== src/jvfc_dp.sv =====
// Datapath: configuration registers, filter state, divide-by-three digit unit,
// friction multiplier and result register. Depends on jvfc_pkg, assert_macros.svh.
`include "assert_macros.svh"

module jvfc_dp import jvfc_pkg::*; #(
	parameter int SAMPLE_RATE_HZ = 1000
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic signed [31:0]    joint_angle,
	input  cmd_t                  cmd,
	output status_t               st,
	output result_t               res
);

	localparam int RATE_W = $clog2(SAMPLE_RATE_HZ + 1);
	localparam int RAW_W  = 33 + RATE_W;
	localparam int SUM_W  = RAW_W + 2;
	localparam logic [RATE_W-1:0] RATE_U = RATE_W'(SAMPLE_RATE_HZ);
	localparam logic signed [64:0] S32_MAX = 65'sd2147483647;
	localparam logic signed [64:0] S32_MIN = -65'sd2147483648;
	localparam logic signed [64:0] HALF_LSB = 65'sd32768;

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		if (v > S32_MAX) begin
			return 32'sh7FFF_FFFF;
		end else if (v < S32_MIN) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// Configuration registers.
	logic [30:0]        min_vel_q;
	logic signed [31:0] visc_pos_q;
	logic signed [31:0] coul_pos_q;
	logic signed [31:0] visc_neg_q;
	logic signed [31:0] coul_neg_q;
	logic signed [31:0] slope_q;
	logic [16:0]        scale_q;

	// Filter state.
	logic signed [31:0] prev_q;
	logic signed [31:0] h1_q;
	logic signed [31:0] h2_q;

	// Working registers.
	logic signed [32:0]      diff_q;
	logic signed [RAW_W-1:0] raw_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    neg_q;
	logic [MAG_W-1:0]        mag_q;
	logic [MAG_W-1:0]        quo_q;
	logic [REM_W-1:0]        rem_q;
	logic [DCNT_W-1:0]       dcnt_q;
	logic signed [31:0]      vel_q;
	logic signed [31:0]      coef_q;
	logic signed [31:0]      off_q;
	logic signed [63:0]      prod_q;
	logic signed [31:0]      t1_q;
	logic signed [49:0]      p2_q;
	result_t                 res_q;

	logic signed [RAW_W:0]   raw_full;
	logic signed [SUM_W-1:0] sum_abs;
	logic [SUM_W:0]          mag_full;
	logic [MAG_W-1:0]        mag_clamped;
	logic [DV_W-1:0]         dv;
	logic [RECIP_W-1:0]      qprod;
	logic [DIGIT_W-1:0]      qdig;
	logic [DV_W-1:0]         rem_full;
	logic signed [31:0]      vel_fin;
	logic signed [32:0]      vel33;
	logic signed [32:0]      minv33;
	logic signed [64:0]      acc_full;
	logic signed [64:0]      rnd_full;

	assign st.div_last = (dcnt_q == DCNT_W'(DIV_DIGITS - 1));
	assign res         = res_q;

	// Raw velocity: angle difference times the sample rate.
	assign raw_full = diff_q * $signed({1'b0, RATE_U});

	// Numerator of the rounded division is |sum| + 1, capped where both signs saturate.
	assign sum_abs  = sum_q[SUM_W-1] ? -sum_q : sum_q;
	assign mag_full = {1'b0, sum_abs} + (SUM_W + 1)'(1);
	assign mag_clamped = (mag_full > (SUM_W + 1)'(MAG_CAP)) ? MAG_CAP : mag_full[MAG_W-1:0];

	// One 12-bit digit of the quotient per cycle through a reciprocal multiply.
	assign dv       = {rem_q, mag_q[MAG_W-1 -: DIGIT_W]};
	assign qprod    = RECIP_W'(dv) * RECIP3;
	assign qdig     = qprod[RECIP_SH +: DIGIT_W];
	assign rem_full = dv - DV_W'(qdig) * DV_W'(3);

	// Signed, saturated velocity from the quotient magnitude.
	always_comb begin
		if (!neg_q) begin
			vel_fin = (quo_q > MAG_W'(64'd2147483647)) ? 32'sh7FFF_FFFF
			                                           : $signed(quo_q[31:0]);
		end else begin
			vel_fin = (quo_q > MAG_W'(64'd2147483648)) ? 32'sh8000_0000
			                                           : $signed(~quo_q[31:0] + 32'd1);
		end
	end

	// Band compare and the two rounding adds.
	assign vel33    = 33'(vel_q);
	assign minv33   = $signed({2'b00, min_vel_q});
	assign acc_full = (65'(prod_q) + (65'(off_q) <<< 16) + HALF_LSB) >>> 16;
	assign rnd_full = (65'(p2_q) + HALF_LSB) >>> 16;

	// Configuration and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_vel_q  <= '0;
			visc_pos_q <= '0;
			coul_pos_q <= '0;
			visc_neg_q <= '0;
			coul_neg_q <= '0;
			slope_q    <= '0;
			scale_q    <= 17'd65536;
			prev_q     <= '0;
			h1_q       <= '0;
			h2_q       <= '0;
			dcnt_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_VELOCITY:   min_vel_q  <= cfg_data[30:0];
					CFG_VISCOUS_POS:    visc_pos_q <= $signed(cfg_data);
					CFG_COULOMB_POS:    coul_pos_q <= $signed(cfg_data);
					CFG_VISCOUS_NEG:    visc_neg_q <= $signed(cfg_data);
					CFG_COULOMB_NEG:    coul_neg_q <= $signed(cfg_data);
					CFG_STATIC_SLOPE:   slope_q    <= $signed(cfg_data);
					CFG_FRICTION_SCALE: scale_q    <= cfg_data[16:0];
					default: begin
					end
				endcase
			end
			if (cmd.load) begin
				prev_q <= joint_angle;
			end
			if (cmd.mag) begin
				dcnt_q <= '0;
			end else if (cmd.div) begin
				dcnt_q <= dcnt_q + DCNT_W'(1);
			end
			if (cmd.vel) begin
				h1_q <= vel_fin;
				h2_q <= h1_q;
			end
		end
	end

	// Working registers, one step per command.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			diff_q <= 33'(joint_angle) - 33'(prev_q);
		end
		if (cmd.raw) begin
			raw_q <= raw_full[RAW_W-1:0];
		end
		if (cmd.sum) begin
			sum_q <= SUM_W'(raw_q) + SUM_W'(h1_q) + SUM_W'(h2_q);
		end
		if (cmd.mag) begin
			neg_q <= sum_q[SUM_W-1];
			mag_q <= mag_clamped;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cmd.div) begin
			mag_q <= mag_q << DIGIT_W;
			rem_q <= rem_full[REM_W-1:0];
			quo_q <= {quo_q[MAG_W-DIGIT_W-1:0], qdig};
		end
		if (cmd.vel) begin
			vel_q <= vel_fin;
		end
		if (cmd.sel) begin
			if (vel33 > minv33) begin
				coef_q <= visc_pos_q;
				off_q  <= coul_pos_q;
			end else if (vel33 < -minv33) begin
				coef_q <= visc_neg_q;
				off_q  <= coul_neg_q;
			end else begin
				coef_q <= slope_q;
				off_q  <= '0;
			end
		end
		if (cmd.mul1) begin
			prod_q <= vel_q * coef_q;
		end
		if (cmd.acc) begin
			t1_q <= sat32(acc_full);
		end
		if (cmd.mul2) begin
			p2_q <= 50'(t1_q) * $signed({33'd0, scale_q});
		end
		if (cmd.rnd2) begin
			res_q.filtered_velocity <= vel_q;
			res_q.friction_torque   <= sat32(rnd_full);
		end
	end

	// The division remainder is always below the divisor.
	`JVFC_ASSERT_IMPL(a_rem_below_three, cmd.div, rem_q != 2'd3)

endmodule

// ===== src/joint_velocity_friction_comp.sv =====
// Channel   Dir  Payload                                Transfer
// sample    in   joint_angle (Q16.16)                   valid & ready
// result    out  filtered_velocity, friction_torque     valid & ready
// cfg       in   cfg_index, cfg_data                    cfg_we high
//
// A sample is taken only once the result of the one before it has been written;
// the sequencer steps once per cycle while no stalled result holds it, and three of
// its steps are spent in the divide-by-three unit, one for each 12-bit digit.
// A new sample is taken in the cycle after the result is written, while that
// result still waits in the output register; a stalled result holds the sequence
// in its last step. Reset clears configuration to its defaults and the filter
// state to zero; there is no clearing pass.
//
// Top level of the joint velocity filter with friction compensation.
// Depends on jvfc_pkg, jvfc_stream_if, jvfc_ctrl and jvfc_dp.
module joint_velocity_friction_comp import jvfc_pkg::*; #(
	parameter int SAMPLE_RATE_HZ = 1000
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	jvfc_stream_if.sink           sample,
	jvfc_stream_if.source         result
);

	cmd_t    cmd;
	status_t st;
	result_t res;

	// Sequencer.
	jvfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd),
		.st        (st)
	);

	// Arithmetic and state.
	jvfc_dp #(
		.SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.joint_angle (sample.payload.joint_angle),
		.cmd         (cmd),
		.st          (st),
		.res         (res)
	);

	assign result.payload = res;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for joint_velocity_friction_comp: angle samples in, velocity and
// friction torque out, each result compared against a cycle-free predictor of the filter.
// Depends on jvfc_pkg, jvfc_stream_if and the joint_velocity_friction_comp RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import jvfc_pkg::*;

	localparam int RATE_HZ = 1000;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_TAIL = 40;
	localparam int MAX_REPORTS = 20;
	localparam longint S32_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam longint S32_MIN = -64'sh0000_0000_8000_0000;
	localparam longint Q_ONE = 65536;
	localparam logic [16:0] SCALE_UNITY = 17'h1_0000;
	// Index that decodes to no register; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

	typedef struct packed {
		logic [30:0]        band;
		logic signed [31:0] vpos_gain;
		logic signed [31:0] cpos_offset;
		logic signed [31:0] vneg_gain;
		logic signed [31:0] cneg_offset;
		logic signed [31:0] slope;
		logic [16:0]        scale;
	} friction_cfg_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	jvfc_stream_if #(.payload_t(sample_t)) sample_ch ();
	jvfc_stream_if #(.payload_t(result_t)) result_ch ();

	joint_velocity_friction_comp #(.SAMPLE_RATE_HZ(RATE_HZ)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	// Predictor state: configuration and filter history as the block should hold them.
	friction_cfg_t fric_now;
	longint prev_angle;
	longint vel_hist1;
	longint vel_hist2;
	result_t pending_results[$];

	// Traffic control shared between the test tasks and the receiver.
	stall_mode_t stall_mode = STALL_RANDOM;
	bit gaps_on = 1'b1;
	int burst_left = 0;
	int hold_request = 0;

	int samples_sent = 0;
	int results_checked = 0;
	int mismatch_count = 0;
	int settings_count = 0;
	int cycle_count = 0;

	logic signed [31:0] far_angles[4] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1};
	int spans[4] = '{4, 64, 1024, 65536};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint clamp_s32(input longint v);
		if (v > S32_MAX)
			return S32_MAX;
		if (v < S32_MIN)
			return S32_MIN;
		return v;
	endfunction

	// Round half up from Q32.32 to Q16.16; the arithmetic shift floors.
	function automatic longint round_q16(input longint v);
		return (v + 32768) >>> 16;
	endfunction

	// Filtered velocity that the next sample would produce, without moving the history.
	function automatic longint next_velocity(input logic signed [31:0] angle);
		longint total;
		total = (longint'(angle) - prev_angle) * RATE_HZ + vel_hist1 + vel_hist2;
		if (total >= 0)
			return clamp_s32((total + 1) / 3);
		return clamp_s32(-((-total + 1) / 3));
	endfunction

	// Velocity and friction torque for one accepted sample; advances the filter history.
	function automatic result_t joint_friction_step(input logic signed [31:0] angle);
		longint vel;
		longint band;
		longint acc;
		longint torque;
		result_t r;
		vel = next_velocity(angle);
		band = longint'(fric_now.band);
		if (vel > band)
			acc = longint'($signed(fric_now.vpos_gain)) * vel +
				longint'($signed(fric_now.cpos_offset)) * Q_ONE;
		else if (vel < -band)
			acc = longint'($signed(fric_now.vneg_gain)) * vel +
				longint'($signed(fric_now.cneg_offset)) * Q_ONE;
		else
			acc = longint'($signed(fric_now.slope)) * vel;
		torque = clamp_s32(round_q16(acc));
		torque = clamp_s32(round_q16(torque * longint'(fric_now.scale)));
		prev_angle = longint'(angle);
		vel_hist2 = vel_hist1;
		vel_hist1 = vel;
		r.filtered_velocity = vel[31:0];
		r.friction_torque = torque[31:0];
		return r;
	endfunction

	// One register write; the caller lowers the enable after its last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_MIN_VELOCITY:   fric_now.band = data[30:0];
			CFG_VISCOUS_POS:    fric_now.vpos_gain = data;
			CFG_COULOMB_POS:    fric_now.cpos_offset = data;
			CFG_VISCOUS_NEG:    fric_now.vneg_gain = data;
			CFG_COULOMB_NEG:    fric_now.cneg_offset = data;
			CFG_STATIC_SLOPE:   fric_now.slope = data;
			CFG_FRICTION_SCALE: fric_now.scale = data[16:0];
			default: ;
		endcase
	endtask

	// Write every register; unused upper data bits carry noise that must be dropped.
	task automatic apply_settings(input friction_cfg_t c);
		logic [31:0] junk;
		junk = $urandom;
		write_reg(CFG_MIN_VELOCITY, {junk[31], c.band});
		write_reg(CFG_VISCOUS_POS, c.vpos_gain);
		write_reg(CFG_COULOMB_POS, c.cpos_offset);
		write_reg(CFG_VISCOUS_NEG, c.vneg_gain);
		write_reg(CFG_COULOMB_NEG, c.cneg_offset);
		write_reg(CFG_STATIC_SLOPE, c.slope);
		write_reg(CFG_FRICTION_SCALE, {junk[14:0], c.scale});
		cfg_we <= 1'b0;
		settings_count++;
	endtask

	// Offer one sample and wait for its transfer; gaps come between random bursts.
	task automatic send_sample(input logic signed [31:0] angle);
		int gap;
		sample_ch.valid <= 1'b1;
		sample_ch.payload.joint_angle <= angle;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		pending_results.push_back(joint_friction_step(angle));
		samples_sent++;
		if (gaps_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, 20);
				sample_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Stop offering and wait until every expected result has been transferred.
	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	function automatic friction_cfg_t random_settings(input int style);
		friction_cfg_t c;
		case (style % 4)
			0: begin
				c.band = 31'($urandom_range(0, 'h40000));
				c.vpos_gain = $urandom_range(0, 'h100000) - 'h80000;
				c.cpos_offset = $urandom_range(0, 'h100000) - 'h80000;
				c.vneg_gain = $urandom_range(0, 'h100000) - 'h80000;
				c.cneg_offset = $urandom_range(0, 'h100000) - 'h80000;
				c.slope = $urandom_range(0, 'h4000000) - 'h2000000;
			end
			1: begin
				c.band = '0;
				c.vpos_gain = $urandom;
				c.cpos_offset = $urandom;
				c.vneg_gain = $urandom;
				c.cneg_offset = $urandom;
				c.slope = $urandom;
			end
			2: begin
				c.band = 31'($urandom);
				c.vpos_gain = $urandom_range(0, 'h100000) - 'h80000;
				c.cpos_offset = $urandom;
				c.vneg_gain = $urandom_range(0, 'h100000) - 'h80000;
				c.cneg_offset = $urandom;
				c.slope = $urandom_range(0, 'h100000) - 'h80000;
			end
			default: begin
				c.band = 31'($urandom_range(0, 'h40000));
				c.vpos_gain = $urandom;
				c.cpos_offset = $urandom;
				c.vneg_gain = $urandom;
				c.cneg_offset = $urandom;
				c.slope = $urandom;
			end
		endcase
		case ($urandom_range(0, 3))
			0: c.scale = SCALE_UNITY;
			1: c.scale = 17'($urandom_range(0, 'h10000));
			2: c.scale = 17'h1_FFFF;
			default: c.scale = 17'($urandom);
		endcase
		return c;
	endfunction

	// Defaults after reset: zero coefficients, and the first sample sees a zero previous angle.
	task automatic test_reset_defaults();
		send_sample(32'sh0001_2345);
		send_sample(32'sh0001_2345);
		send_sample(-32'sh0000_0100);
		send_sample(32'sd0);
		wait_drained();
	endtask

	// Sliding branches, both band edges and the static band, with a band set per sample.
	task automatic test_friction_branches();
		friction_cfg_t c;
		logic signed [31:0] angle;
		longint stride;
		longint vel;
		longint speed;
		c.band = 31'h8000;
		c.vpos_gain = 32'sh0001_8000;
		c.cpos_offset = 32'sh0000_4000;
		c.vneg_gain = 32'sh0002_0000;
		c.cneg_offset = -32'sh0000_4000;
		c.slope = 32'sh0030_0000;
		c.scale = 17'h0_C000;
		apply_settings(c);
		@(posedge clk);
		for (int i = 0; i < 6; i++) begin
			// A step this large forces the sign of the velocity whatever the history holds.
			stride = (vel_hist1 < 0 ? -vel_hist1 : vel_hist1) +
				(vel_hist2 < 0 ? -vel_hist2 : vel_hist2);
			stride = stride / RATE_HZ + 1000;
			angle = prev_angle[31:0] + ((i % 2) ? -stride[31:0] : stride[31:0]);
			vel = next_velocity(angle);
			speed = (vel < 0) ? -vel : vel;
			// Pairs of samples: just outside the band, exactly on its edge, deep inside.
			case (i / 2)
				0: speed = speed - 1;
				1: ;
				default: speed = speed + 1000;
			endcase
			if (speed > S32_MAX)
				speed = S32_MAX;
			if (speed < 0)
				speed = 0;
			write_reg(CFG_MIN_VELOCITY, speed[31:0]);
			cfg_we <= 1'b0;
			send_sample(angle);
			wait_drained();
		end
	endtask

	// A write to an index past the last register must leave the settings alone.
	task automatic test_unknown_register();
		write_reg(CFG_UNUSED_IDX, $urandom);
		cfg_we <= 1'b0;
		send_sample(prev_angle[31:0] + 32'sd300);
		send_sample(prev_angle[31:0] - 32'sd900);
		wait_drained();
	endtask

	// Field extremes with coefficients and scale at their limits, then a zero scale and minus one LSB.
	task automatic test_saturation();
		friction_cfg_t c;
		c.band = '0;
		c.vpos_gain = 32'sh7FFF_FFFF;
		c.cpos_offset = 32'sh7FFF_FFFF;
		c.vneg_gain = 32'sh8000_0000;
		c.cneg_offset = 32'sh8000_0000;
		c.slope = 32'sh7FFF_FFFF;
		c.scale = 17'h1_FFFF;
		apply_settings(c);
		send_sample(32'sh7FFF_FFFF);
		send_sample(32'sh8000_0000);
		send_sample(32'sh8000_0000);
		send_sample(32'sh7FFF_FFFF);
		wait_drained();
		// Widest band with the most negative slope and a zero scale.
		c.band = 31'h7FFF_FFFF;
		c.slope = 32'sh8000_0000;
		c.scale = '0;
		apply_settings(c);
		send_sample(32'sh8000_0000);
		send_sample(32'sd0);
		wait_drained();
		// All coefficients at minus one LSB, unity scale.
		c.band = '0;
		c.vpos_gain = -32'sd1;
		c.cpos_offset = -32'sd1;
		c.vneg_gain = -32'sd1;
		c.cneg_offset = -32'sd1;
		c.slope = -32'sd1;
		c.scale = SCALE_UNITY;
		apply_settings(c);
		send_sample(-32'sd1);
		send_sample(32'sd1);
		wait_drained();
	endtask

	// The receiver holds off for a long stretch while samples keep coming back to back.
	task automatic test_backpressure();
		logic signed [31:0] angle;
		gaps_on = 1'b0;
		stall_mode = STALL_NONE;
		hold_request = 300;
		angle = prev_angle[31:0];
		for (int i = 0; i < 24; i++) begin
			angle = angle + $urandom_range(0, 2000) - 1000;
			send_sample(angle);
		end
		wait_drained();
		gaps_on = 1'b1;
		stall_mode = STALL_RANDOM;
	endtask

	// Phases of random settings; mostly smooth motion, some noise and jumps to the extremes.
	task automatic test_random_motion(input int phases, input int per_phase);
		logic signed [31:0] angle;
		int drift;
		int jitter;
		int span;
		int pick;
		int seg;
		for (int p = 0; p < phases; p++) begin
			wait_drained();
			apply_settings(random_settings(p));
			stall_mode = stall_mode_t'(p % 3);
			gaps_on = (p % 3 != 0);
			angle = prev_angle[31:0];
			for (int i = 0; i < per_phase; ) begin
				pick = $urandom_range(0, 9);
				span = spans[2'($urandom_range(0, 3))];
				drift = $urandom_range(0, 2 * span);
				drift -= span;
				seg = $urandom_range(4, 16);
				for (int j = 0; j < seg && i < per_phase; j++) begin
					if (pick < 7) begin
						jitter = $urandom_range(0, 2 * span);
						jitter -= span;
						angle = angle + drift + jitter;
					end else if (pick < 9) begin
						angle = $urandom;
					end else begin
						angle = far_angles[2'($urandom_range(0, 3))];
					end
					send_sample(angle);
					i++;
				end
			end
		end
		wait_drained();
	endtask

	// Receiver: stalls on its own pattern, plus long hold-offs on request.
	initial begin : result_sink
		int held;
		int unsigned beat;
		result_ch.ready = 1'b0;
		beat = 0;
		forever begin
			@(posedge clk);
			beat++;
			if (hold_request > 0) begin
				held = hold_request;
				hold_request = 0;
				result_ch.ready <= 1'b0;
				repeat (held) @(posedge clk);
			end
			case (stall_mode)
				STALL_NONE:    result_ch.ready <= 1'b1;
				STALL_RANDOM:  result_ch.ready <= ($urandom_range(0, 3) != 0);
				STALL_PATTERN: result_ch.ready <= ((beat % 7) < 4);
				default:       result_ch.ready <= 1'b1;
			endcase
		end
	end

	// Compare each result transfer with the oldest expectation, field by field.
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: result with nothing expected, velocity %0d torque %0d", $time,
					result_ch.payload.filtered_velocity, result_ch.payload.friction_torque);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (result_ch.payload.filtered_velocity !== want.filtered_velocity) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: filtered_velocity expected %0d, got %0d", $time,
							want.filtered_velocity, result_ch.payload.filtered_velocity);
				end
				if (result_ch.payload.friction_torque !== want.friction_torque) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: friction_torque expected %0d, got %0d", $time,
							want.friction_torque, result_ch.payload.friction_torque);
				end
			end
		end
	end

	// Watchdog on the total run length.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	// Test sequence.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.payload = '0;
		fric_now = '0;
		fric_now.scale = SCALE_UNITY;
		prev_angle = 0;
		vel_hist1 = 0;
		vel_hist2 = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_friction_branches();
		test_unknown_register();
		test_saturation();
		test_backpressure();
		test_random_motion(6, 80);

		wait_drained();
		repeat (DRAIN_TAIL) @(posedge clk);
		$display("Run covered %0d angle samples under %0d friction settings,", samples_sent,
			settings_count);
		$display("including band edges, saturation and a long output hold; %0d results compared.",
			results_checked);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/jvfc_pkg.sv
src/jvfc_stream_if.sv
src/jvfc_ctrl.sv
src/jvfc_dp.sv
src/joint_velocity_friction_comp.sv
tb/testbench.sv
